FILE: rtl/tpw_pkg.sv
// Shared constants, types and the arctangent table for the plane wave generator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package tpw_pkg;

  localparam int GRID_BITS     = 10;
  localparam int GRID_REG_W    = GRID_BITS + 1;
  localparam int PHASE_W       = 32;
  localparam int AMP_W         = 16;
  localparam int OUT_W         = 16;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CORDIC_STAGES = 16;

  // Datapath widths: x/y grow by the CORDIC gain on top of amplitude*gain (< 2^32).
  localparam int XW = 35;
  localparam int ZW = 33;

  // 0.60725 in Q0.16, cancels the CORDIC gain
  localparam logic [AMP_W-1:0] CORDIC_GAIN = 16'd39797;

  // atan(2^-i) in turns scaled by 2^32
  localparam logic [PHASE_W-1:0] ATAN_TURNS [CORDIC_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_WIDTH   = 3'd0,
    REG_GRID_HEIGHT  = 3'd1,
    REG_PHASE_STEP_X = 3'd2,
    REG_PHASE_STEP_Y = 3'd3,
    REG_AMPLITUDE    = 3'd4,
    REG_REVERSE_TILT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } cordic_t;

endpackage

`default_nettype wire

FILE: rtl/tilted_plane_wave_generator.sv
// Tilted plane wave generator: one complex sample amplitude*exp(j*phase) per pixel.
// Top level: configuration registers, phase front end, CORDIC, output stage.
// Depends on tpw_pkg, tpw_phase, tpw_cordic, tpw_round.
//
// Usage:
//   Input channel (in_valid/in_ready) carries column_index and row_index of a
//   pixel; output channel (out_valid/out_ready) returns real_part and
//   imag_part in Q1.15. One result per transfer, in input order.
//   The pipeline has 3 phase stages (offset, step multiply, phase sum and
//   fold), 16 CORDIC micro-rotation stages and 1 rounding/output register.
//   Throughput is one pixel per cycle while the receiver accepts; every stage
//   has its own valid bit and a stage takes new data whenever it is empty or
//   its successor moves, so bubbles collapse while the receiver stalls and
//   the front keeps accepting until all 20 stages are full.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register;
//   write only while no pixel is in flight.
//   Reset clears the pipeline and loads grid 1024 x 1024, zero steps, full
//   amplitude and no reverse tilt.
`default_nettype none

module tilted_plane_wave_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tpw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tpw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tpw_pkg::GRID_BITS-1:0]       column_index,
  input  logic [tpw_pkg::GRID_BITS-1:0]       row_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tpw_pkg::OUT_W-1:0]    real_part,
  output logic signed [tpw_pkg::OUT_W-1:0]    imag_part
);
  import tpw_pkg::*;

  logic [GRID_REG_W-1:0]      grid_width, grid_height;
  logic signed [PHASE_W-1:0]  phase_step_x, phase_step_y;
  logic [AMP_W-1:0]           amplitude;
  logic                       reverse_tilt;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= {1'b1, {GRID_BITS{1'b0}}};
      grid_height  <= {1'b1, {GRID_BITS{1'b0}}};
      phase_step_x <= '0;
      phase_step_y <= '0;
      amplitude    <= '1;
      reverse_tilt <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:   grid_width   <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_HEIGHT:  grid_height  <= cfg_data[GRID_REG_W-1:0];
        REG_PHASE_STEP_X: phase_step_x <= $signed(cfg_data[PHASE_W-1:0]);
        REG_PHASE_STEP_Y: phase_step_y <= $signed(cfg_data[PHASE_W-1:0]);
        REG_AMPLITUDE:    amplitude    <= cfg_data[AMP_W-1:0];
        REG_REVERSE_TILT: reverse_tilt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic    ph_valid, ph_ready;
  cordic_t ph_data;
  logic    cr_valid, cr_ready;
  cordic_t cr_data;

  tpw_phase u_phase (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .column_index (column_index),
    .row_index    (row_index),
    .grid_width   (grid_width),
    .grid_height  (grid_height),
    .phase_step_x (phase_step_x),
    .phase_step_y (phase_step_y),
    .amplitude    (amplitude),
    .reverse_tilt (reverse_tilt),
    .out_valid    (ph_valid),
    .out_ready    (ph_ready),
    .out_data     (ph_data)
  );

  tpw_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ph_valid),
    .in_ready  (ph_ready),
    .in_data   (ph_data),
    .out_valid (cr_valid),
    .out_ready (cr_ready),
    .out_data  (cr_data)
  );

  tpw_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cr_valid),
    .in_ready  (cr_ready),
    .in_data   (cr_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .real_part (real_part),
    .imag_part (imag_part)
  );

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a ready receiver must open the whole pipe
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while receiver is ready");

  // the front only blocks when a result is held back
  a_block_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked without a stalled result");

endmodule

`default_nettype wire

FILE: rtl/tpw_phase.sv
// Phase front end: pixel offsets, step multiplies, phase sum and quadrant fold.
// Three register stages with valid/ready ripple. Depends on tpw_pkg.
`default_nettype none

module tpw_phase (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tpw_pkg::GRID_BITS-1:0]       column_index,
  input  logic [tpw_pkg::GRID_BITS-1:0]       row_index,
  input  logic [tpw_pkg::GRID_REG_W-1:0]      grid_width,
  input  logic [tpw_pkg::GRID_REG_W-1:0]      grid_height,
  input  logic signed [tpw_pkg::PHASE_W-1:0]  phase_step_x,
  input  logic signed [tpw_pkg::PHASE_W-1:0]  phase_step_y,
  input  logic [tpw_pkg::AMP_W-1:0]           amplitude,
  input  logic                                reverse_tilt,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tpw_pkg::cordic_t                    out_data
);
  import tpw_pkg::*;

  // stage 1: offsets from grid center, start vector
  logic                        v1, rdy1;
  logic signed [GRID_BITS:0]   dx1, dy1;
  logic [2*AMP_W-1:0]          x01;
  // stage 2: step products (mod 2^32)
  logic                        v2, rdy2;
  logic [PHASE_W-1:0]          px2, py2;
  logic [2*AMP_W-1:0]          x02;
  // stage 3: folded phase
  logic                        v3, rdy3;
  cordic_t                     st3;

  logic signed [GRID_BITS:0]            dx_next, dy_next;
  logic signed [PHASE_W-1:0]            prod_x, prod_y;
  logic [PHASE_W-1:0]                   sum, ph, ph_fold;
  logic                                 flip;
  cordic_t                              st3_next;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign dx_next = $signed({1'b0, column_index}) - $signed({1'b0, grid_width[GRID_BITS:1]});
  assign dy_next = $signed({1'b0, row_index}) - $signed({1'b0, grid_height[GRID_BITS:1]});

  // only the low 32 bits of the product matter
  assign prod_x = phase_step_x * PHASE_W'(dx1);
  assign prod_y = phase_step_y * PHASE_W'(dy1);

  always_comb begin
    sum     = px2 + py2;
    ph      = reverse_tilt ? (~sum + PHASE_W'(1)) : sum;
    // quadrants 1 and 2: rotate by half a turn, negate the result later
    flip    = ph[PHASE_W-1] ^ ph[PHASE_W-2];
    ph_fold = {ph[PHASE_W-1] ^ flip, ph[PHASE_W-2:0]};
    st3_next.x    = $signed({{(XW-2*AMP_W){1'b0}}, x02});
    st3_next.y    = '0;
    st3_next.z    = $signed({ph_fold[PHASE_W-1], ph_fold});
    st3_next.flip = flip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dx1 <= dx_next;
      dy1 <= dy_next;
      x01 <= (2*AMP_W)'(amplitude) * (2*AMP_W)'(CORDIC_GAIN);
    end
    if (rdy2 && v1) begin
      px2 <= prod_x;
      py2 <= prod_y;
      x02 <= x01;
    end
    if (rdy3 && v2) begin
      st3 <= st3_next;
    end
  end

  assign out_valid = v3;
  assign out_data  = st3;

endmodule

`default_nettype wire

FILE: rtl/tpw_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per register stage.
// Valid/ready ripple across the stages. Depends on tpw_pkg.
`default_nettype none

module tpw_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tpw_pkg::cordic_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tpw_pkg::cordic_t out_data
);
  import tpw_pkg::*;

  logic    v   [CORDIC_STAGES];
  logic    rdy [CORDIC_STAGES];
  cordic_t st  [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    cordic_t              src;
    logic                 src_v;
    logic                 down_rdy;
    cordic_t              nxt;
    logic signed [XW-1:0] sx, sy;
    logic signed [ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign src   = in_data;
      assign src_v = in_valid;
    end else begin : g_mid
      assign src   = st[i-1];
      assign src_v = v[i-1];
    end

    if (i == CORDIC_STAGES - 1) begin : g_last
      assign down_rdy = out_ready;
    end else begin : g_inner
      assign down_rdy = rdy[i+1];
    end

    assign rdy[i] = !v[i] || down_rdy;
    assign sx     = src.x >>> i;
    assign sy     = src.y >>> i;
    assign ang    = $signed({1'b0, ATAN_TURNS[i]});

    always_comb begin
      nxt.flip = src.flip;
      if (!src.z[ZW-1]) begin
        nxt.x = src.x - sy;
        nxt.y = src.y + sx;
        nxt.z = src.z - ang;
      end else begin
        nxt.x = src.x + sy;
        nxt.y = src.y - sx;
        nxt.z = src.z + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v) begin
        st[i] <= nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[CORDIC_STAGES-1];
  assign out_data  = st[CORDIC_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/tpw_round.sv
// Output stage: half-turn sign fix, rounding to Q1.15 and saturation.
// Holds the result until transfer. Depends on tpw_pkg.
`default_nettype none

module tpw_round (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tpw_pkg::cordic_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tpw_pkg::OUT_W-1:0]  real_part,
  output logic signed [tpw_pkg::OUT_W-1:0]  imag_part
);
  import tpw_pkg::*;

  localparam int RND_SHIFT = 17;
  localparam int RW        = XW + 1 - RND_SHIFT;
  localparam logic signed [RW-1:0] Q_MAX = RW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [RW-1:0] Q_MIN = -RW'(1 << (OUT_W - 1));

  function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [XW-1:0] v,
                                                      input logic flip);
    logic signed [XW:0]   s;
    logic signed [XW:0]   t;
    logic signed [RW-1:0] r;
    s = $signed({v[XW-1], v});
    if (flip) s = -s;
    t = s + $signed((XW+1)'(1 << (RND_SHIFT - 1)));
    r = $signed(t[XW:RND_SHIFT]);
    if (r > Q_MAX)      return Q_MAX[OUT_W-1:0];
    else if (r < Q_MIN) return Q_MIN[OUT_W-1:0];
    else                return r[OUT_W-1:0];
  endfunction

  logic vout;

  assign in_ready  = !vout || out_ready;
  assign out_valid = vout;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (in_ready) begin
      vout <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      real_part <= to_q15(in_data.x, in_data.flip);
      imag_part <= to_q15(in_data.y, in_data.flip);
    end
  end

endmodule

`default_nettype wire
